// ----- hdl/aabb_wall_pushout_assert.svh -----
// Assertion macros shared by the push-out block.
`ifndef AABB_WALL_PUSHOUT_ASSERT_SVH
`define AABB_WALL_PUSHOUT_ASSERT_SVH

// cons must hold in the same cycle as ante
`define AWP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define AWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/aabbwp_pkg.sv -----
// Types and constants shared by the push-out block.
`timescale 1ns / 1ps

package aabbwp_pkg;

  localparam int COORD_W = 32;
  localparam int HALF_W  = 31;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0]  half_t;

  // one collider entry: center and half extents, x in [0]
  typedef struct packed {
    coord_t [2:0] c;
    half_t  [2:0] h;
  } entry_t;

  // query beat moving down the cell row
  typedef struct packed {
    coord_t [2:0]     c;
    half_t  [2:0]     h;
    coord_t [2:0]     p;
    logic [CNT_W-1:0] contacts;
  } beat_t;

endpackage

// ----- hdl/aabbwp_cell.sv -----
// One collider cell: holds an entry and resolves the passing query box against it.
`timescale 1ns / 1ps

module aabbwp_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                active,
  input  logic                wr_en,
  input  aabbwp_pkg::entry_t  wr_entry,
  input  logic                in_valid,
  input  aabbwp_pkg::beat_t   in_beat,
  output logic                out_valid,
  output aabbwp_pkg::beat_t   out_beat
);

  localparam int DW = aabbwp_pkg::COORD_W + 1;  // center difference
  localparam int SW = aabbwp_pkg::HALF_W + 1;   // half extent sum
  localparam int OW = aabbwp_pkg::COORD_W + 2;  // overlap

  aabbwp_pkg::entry_t entry;

  logic              s1_valid;
  aabbwp_pkg::beat_t s1;
  logic [DW-1:0]     diff      [3];
  logic [DW-1:0]     diff_next [3];
  logic [SW-1:0]     hsum      [3];
  logic [SW-1:0]     hsum_next [3];

  aabbwp_pkg::beat_t out_beat_next;

  // saturating add of a signed overlap to a 32-bit signed coordinate
  function automatic aabbwp_pkg::coord_t sat_add(input aabbwp_pkg::coord_t a,
                                                 input logic [OW-1:0] b);
    logic [OW:0] s;
    s = {{3{a[aabbwp_pkg::COORD_W-1]}}, a} + {b[OW-1], b};
    if (!s[OW] && (s[OW-1:aabbwp_pkg::COORD_W-1] != '0)) begin
      return {1'b0, {(aabbwp_pkg::COORD_W-1){1'b1}}};
    end else if (s[OW] && (s[OW-1:aabbwp_pkg::COORD_W-1] != '1)) begin
      return {1'b1, {(aabbwp_pkg::COORD_W-1){1'b0}}};
    end else begin
      return s[aabbwp_pkg::COORD_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  // stage 1: signed center difference and summed half extents per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff_next[a] = {in_beat.c[a][aabbwp_pkg::COORD_W-1], in_beat.c[a]}
                   - {entry.c[a][aabbwp_pkg::COORD_W-1], entry.c[a]};
      hsum_next[a] = {1'b0, in_beat.h[a]} + {1'b0, entry.h[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_beat;
      for (int a = 0; a < 3; a++) begin
        diff[a] <= diff_next[a];
        hsum[a] <= hsum_next[a];
      end
    end
  end

  // stage 2: overlaps, smallest axis, push
  always_comb begin
    logic [DW-1:0] absd;
    logic [OW-1:0] d [3];
    logic          gt [3];
    logic          hit;
    logic [1:0]    ax;
    logic [OW-1:0] push;
    for (int a = 0; a < 3; a++) begin
      absd  = diff[a][DW-1] ? (DW'(0) - diff[a]) : diff[a];
      d[a]  = {2'b00, hsum[a]} - {1'b0, absd};
      gt[a] = !diff[a][DW-1] && (diff[a] != '0);
    end
    hit = active;
    for (int a = 0; a < 3; a++) begin
      hit = hit && !d[a][OW-1] && (d[a] != '0);
    end
    priority if (($signed(d[0]) <= $signed(d[1])) && ($signed(d[0]) <= $signed(d[2]))) begin
      ax = 2'd0;
    end else if (($signed(d[1]) <= $signed(d[0])) && ($signed(d[1]) <= $signed(d[2]))) begin
      ax = 2'd1;
    end else begin
      ax = 2'd2;
    end
    // equal centers push toward negative
    push = gt[ax] ? d[ax] : (OW'(0) - d[ax]);
    out_beat_next = s1;
    if (hit) begin
      out_beat_next.c[ax]    = sat_add(s1.c[ax], push);
      out_beat_next.p[ax]    = sat_add(s1.p[ax], push);
      out_beat_next.contacts = s1.contacts + aabbwp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat <= out_beat_next;
    end
  end

endmodule

// ----- hdl/aabb_wall_pushout.sv -----
// Box push-out against a row of collider cells: a query box steps through the
// cells one by one and is moved out of every overlapping collider in turn.
// Write beats store one collider. A query beat walks the whole row of two-stage
// cells whatever collider_count is; cells at or above collider_count pass it
// unchanged. One query is in the row at a time, so a new beat is taken the
// cycle after the result moves to the output register. The row halts while a
// finished result waits on a full output register.
`timescale 1ns / 1ps

module aabb_wall_pushout #(
  parameter int MAX_COLLIDERS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [5:0]          entry_index,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         half_x,
  input  logic [30:0]         half_y,
  input  logic [30:0]         half_z,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  new_pos_x,
  output logic signed [31:0]  new_pos_y,
  output logic signed [31:0]  new_pos_z,
  output logic [6:0]          contacts
);

  logic [aabbwp_pkg::CNT_W-1:0] collider_count;
  logic                         busy;
  logic                         en;
  logic                         accept;
  logic                         acc_query;
  logic                         acc_write;
  logic                         tail_valid;

  aabbwp_pkg::entry_t wr_entry;
  aabbwp_pkg::beat_t  head;
  aabbwp_pkg::beat_t  chain_beat  [MAX_COLLIDERS+1];
  logic               chain_valid [MAX_COLLIDERS+1];
  aabbwp_pkg::beat_t  result;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign acc_query = accept && (req_type == aabbwp_pkg::REQ_QUERY);
  assign acc_write = accept && (req_type == aabbwp_pkg::REQ_WRITE);

  assign tail_valid = chain_valid[MAX_COLLIDERS];
  // halt the row while a finished beat waits on a full output register
  assign en = !(tail_valid && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      collider_count <= '0;
    end else if (cfg_we) begin
      collider_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc_query) begin
      busy <= 1'b1;
    end else if (tail_valid && en) begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    wr_entry.c = {center_z, center_y, center_x};
    wr_entry.h = {half_z, half_y, half_x};
    head.c        = {center_z, center_y, center_x};
    head.h        = {half_z, half_y, half_x};
    head.p        = {pos_z, pos_y, pos_x};
    head.contacts = '0;
  end

  assign chain_beat[0]  = head;
  assign chain_valid[0] = acc_query;

  for (genvar i = 0; i < MAX_COLLIDERS; i++) begin : g_cell
    logic active;
    logic wr_en;
    assign active = 32'(collider_count) > 32'(i);
    assign wr_en  = acc_write && (32'(entry_index) == 32'(i));

    aabbwp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .active    (active),
      .wr_en     (wr_en),
      .wr_entry  (wr_entry),
      .in_valid  (chain_valid[i]),
      .in_beat   (chain_beat[i]),
      .out_valid (chain_valid[i+1]),
      .out_beat  (chain_beat[i+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tail_valid && en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_valid && en) begin
      result <= chain_beat[MAX_COLLIDERS];
    end
  end

  assign new_pos_x = result.p[0];
  assign new_pos_y = result.p[1];
  assign new_pos_z = result.p[2];
  assign contacts  = result.contacts;

`include "aabb_wall_pushout_assert.svh"

  `AWP_ASSERT_NEXT(a_query_sets_busy, acc_query, busy, "query beat did not mark block busy")
  `AWP_ASSERT_NOW(a_tail_needs_busy, tail_valid, busy, "beat at row end while block idle")
  `AWP_ASSERT_NOW(a_result_from_row, $rose(out_valid), $past(tail_valid), "result without beat")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the box push-out block: directed and random beats.
`timescale 1ns / 1ps

module tb;
  import aabbwp_pkg::*;

  localparam int MAXC = 64;
  localparam int ONE = 1 << 16;
  localparam int DRAIN_CYCLES = 2 * MAXC + 8;

  typedef struct packed {
    req_t             kind;
    logic [IDX_W-1:0] slot;
    coord_t [2:0]     c;
    half_t  [2:0]     h;
    coord_t [2:0]     p;
  } pend_beat_t;

  typedef struct packed {
    coord_t [2:0]     p;
    logic [CNT_W-1:0] hits;
  } pushout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic [6:0] contacts;

  pend_beat_t cur_beat = '0;
  pend_beat_t nxt_beat;
  pend_beat_t beat_q[$];
  pushout_t pushout_exp_q[$];
  pushout_t want, got;

  entry_t collider_tbl [MAXC];
  logic [6:0] collider_cnt = '0;
  bit no_idle = 1'b0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  int errors = 0;
  int n_writes = 0, n_queries = 0, n_results = 0, n_pushes = 0, n_settings = 0;
  string axis_name [3] = '{"new_pos_x", "new_pos_y", "new_pos_z"};

  aabb_wall_pushout #(.MAX_COLLIDERS(MAXC)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(cur_beat.kind), .entry_index(cur_beat.slot),
    .center_x(cur_beat.c[0]), .center_y(cur_beat.c[1]), .center_z(cur_beat.c[2]),
    .half_x(cur_beat.h[0]), .half_y(cur_beat.h[1]), .half_z(cur_beat.h[2]),
    .pos_x(cur_beat.p[0]), .pos_y(cur_beat.p[1]), .pos_z(cur_beat.p[2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
    .contacts(contacts)
  );

  always #5 clk = ~clk;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // walks colliders 0..min(count, MAXC)-1, moving the box out of each one it overlaps
  function automatic pushout_t predict_pushout(input pend_beat_t b);
    longint bc [3], bh [3], pp [3], ov [3], kc [3], sep, shove;
    int a, i, n, ax;
    pushout_t r;
    r = '0;
    for (a = 0; a < 3; a++) begin
      bc[a] = longint'($signed(b.c[a]));
      bh[a] = longint'(b.h[a]);
      pp[a] = longint'($signed(b.p[a]));
    end
    n = (collider_cnt > MAXC) ? MAXC : int'(collider_cnt);
    for (i = 0; i < n; i++) begin
      for (a = 0; a < 3; a++) begin
        kc[a] = longint'($signed(collider_tbl[i].c[a]));
        sep = (bc[a] > kc[a]) ? bc[a] - kc[a] : kc[a] - bc[a];
        ov[a] = bh[a] + longint'(collider_tbl[i].h[a]) - sep;
      end
      if (ov[0] > 0 && ov[1] > 0 && ov[2] > 0) begin
        if (ov[0] <= ov[1] && ov[0] <= ov[2]) ax = 0;
        else if (ov[1] <= ov[2]) ax = 1;
        else ax = 2;
        // equal centers push toward negative
        shove = (bc[ax] > kc[ax]) ? ov[ax] : -ov[ax];
        pp[ax] = sat32(pp[ax] + shove);
        bc[ax] = sat32(bc[ax] + shove);
        r.hits = r.hits + CNT_W'(1);
      end
    end
    for (a = 0; a < 3; a++) r.p[a] = pp[a][31:0];
    return r;
  endfunction

  // half extents come in as 32-bit words; the top bit is dropped
  function automatic pend_beat_t pack_beat(input req_t k, input logic [IDX_W-1:0] s,
                                           input coord_t cx, cy, cz,
                                           input coord_t hx, hy, hz,
                                           input coord_t px, py, pz);
    pend_beat_t b;
    b.kind = k;
    b.slot = s;
    b.c[0] = cx; b.c[1] = cy; b.c[2] = cz;
    b.h[0] = hx[HALF_W-1:0]; b.h[1] = hy[HALF_W-1:0]; b.h[2] = hz[HALF_W-1:0];
    b.p[0] = px; b.p[1] = py; b.p[2] = pz;
    return b;
  endfunction

  // mostly a +-20 world, often on a half-unit grid so overlaps tie
  function automatic coord_t rnd_coord();
    int v;
    v = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
    if ($urandom_range(0, 2) == 0) v = v & ~(ONE / 2 - 1);
    if ($urandom_range(0, 9) < 2) v = $urandom();
    return v;
  endfunction

  function automatic coord_t rnd_half();
    int v;
    v = int'($urandom_range(0, 6 * ONE));
    if ($urandom_range(0, 2) == 0) v = v & ~(ONE / 2 - 1);
    case ($urandom_range(0, 19))
      0: v = 0;
      1, 2, 3: v = $urandom();
      default: ;
    endcase
    return {1'b0, v[HALF_W-1:0]};
  endfunction

  function automatic coord_t rnd_pos();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom();
      3, 4, 5: return 32'h7FFF_0000 | ($urandom() & 32'h0000_FFFF);
      6, 7: return 32'h8000_0000 | ($urandom() & 32'h0000_FFFF);
      default: return rnd_coord();
    endcase
  endfunction

  function automatic pend_beat_t rnd_beat(input req_t k, input logic [IDX_W-1:0] s);
    return pack_beat(k, s, rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_half(), rnd_half(), rnd_half(),
                     rnd_pos(), rnd_pos(), rnd_pos());
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  // driver: table and expectations are updated on the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_beat.kind == REQ_WRITE) begin
          collider_tbl[cur_beat.slot] = '{c: cur_beat.c, h: cur_beat.h};
          n_writes++;
        end else begin
          pushout_exp_q.push_back(predict_pushout(cur_beat));
          n_queries++;
        end
      end
      if (!in_valid || in_ready) begin
        if (hold_cnt != 0) begin
          in_valid <= 1'b0;
          hold_cnt <= hold_cnt - 1;
        end else if (beat_q.size() != 0) begin
          nxt_beat = beat_q.pop_front();
          cur_beat <= nxt_beat;
          in_valid <= 1'b1;
          hold_cnt <= (no_idle || $urandom_range(0, 99) >= 35) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: one result beat per query, compared in order
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pushout_exp_q.size() == 0) begin
          $error("result beat with no query pending");
          errors++;
        end else begin
          want = pushout_exp_q.pop_front();
          got.p[0] = new_pos_x;
          got.p[1] = new_pos_y;
          got.p[2] = new_pos_z;
          got.hits = contacts;
          for (int a = 0; a < 3; a++) begin
            if (got.p[a] !== want.p[a]) begin
              $error("%s: expected %0d, actual %0d", axis_name[a],
                     $signed(want.p[a]), $signed(got.p[a]));
              errors++;
            end
          end
          if (got.hits !== want.hits) begin
            $error("contacts: expected %0d, actual %0d", want.hits, got.hits);
            errors++;
          end
          n_results++;
          n_pushes += int'(want.hits);
        end
      end
      if (stall_cnt != 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) stall_cnt <= pick_gap();
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (beat_q.size() != 0 || in_valid || pushout_exp_q.size() != 0) @(negedge clk);
    // a trailing write beat gives no result, so allow a full row pass
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_collider_count(input logic [6:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    collider_cnt = v;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin
    bit written [MAXC];
    int ph, k, i, n, lim;
    logic [IDX_W-1:0] s;
    for (i = 0; i < MAXC; i++) written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // no colliders checked: position passes through untouched
    set_collider_count(7'd0);
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    beat_q.push_back(pack_beat(REQ_WRITE, 6'd0, 0, 0, 0, ONE, ONE, ONE, -1, -1, -1));
    beat_q.push_back(pack_beat(REQ_WRITE, 6'd1, 10 * ONE, 0, 0, ONE, 2 * ONE, 2 * ONE, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_WRITE, 6'd2, -10 * ONE, -10 * ONE, -10 * ONE,
                               2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0));
    for (i = 0; i < 3; i++) written[i] = 1'b1;
    set_collider_count(7'd3);
    // x smallest, x/y tie, y/z tie, z smallest with negative side, all equal centers
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, ONE / 2, ONE / 4, 0, ONE, ONE, ONE, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, ONE / 2, ONE / 2, 0, ONE, ONE, ONE, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 0, ONE / 2, ONE / 2, ONE, ONE, ONE, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 0, 0, -3 * ONE / 4, ONE, ONE, ONE, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE));
    // touching faces: zero overlap is no contact
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 2 * ONE, 0, 0, ONE, ONE, ONE, 0, 0, 0));
    // pushed off collider 0 into collider 1, which pushes back
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 5 * ONE, 0, 0, 9 * ONE / 2, ONE, ONE, 0, 0, 0));
    // position saturates high, then low
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, ONE / 2, ONE / 4, 0, ONE, ONE, ONE,
                               32'h7FFF_0000, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd5, 0, 0, 0, ONE, ONE, ONE, 32'h8000_0000, 0, 0));

    // huge collider at the top corner: wide overlaps and position saturation
    beat_q.push_back(pack_beat(REQ_WRITE, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    set_collider_count(7'd1);
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd0, 0, 0, 0,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    beat_q.push_back(pack_beat(REQ_QUERY, 6'd0, 32'h7FFF_FFFF, 0, 0,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 1;
        1: n = $urandom_range(2, 8);
        2: n = MAXC;
        3: n = 127;
        4: n = 0;
        5: n = $urandom_range(9, 63);
        6: n = $urandom_range(65, 126);
        default: n = $urandom_range(2, 8);
      endcase
      lim = (n > MAXC) ? MAXC : n;
      // every slot a query will read must hold a collider first
      for (i = 0; i < lim; i++) begin
        if (!written[i]) begin
          beat_q.push_back(rnd_beat(REQ_WRITE, i[IDX_W-1:0]));
          written[i] = 1'b1;
        end
      end
      set_collider_count(n[6:0]);
      no_idle = (ph % 3 == 1);
      for (k = 0; k < 125; k++) begin
        if (k == 62) wait_drained();
        if ($urandom_range(0, 3) == 0) begin
          s = IDX_W'($urandom_range(0, MAXC - 1));
          beat_q.push_back(rnd_beat(REQ_WRITE, s));
          written[s] = 1'b1;
        end else begin
          beat_q.push_back(rnd_beat(REQ_QUERY, IDX_W'($urandom_range(0, MAXC - 1))));
        end
      end
    end

    wait_drained();
    $display("Covered %0d collider writes and %0d queries over %0d count settings, 0 to 127.",
             n_writes, n_queries, n_settings);
    $display("Checked %0d results carrying %0d pushes, with ties and saturation included.",
             n_results, n_pushes);
    if (errors == 0 && pushout_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
